>>> hw/rtl/okvt_pkg.sv
// shared types, operation codes and default sizes for the ordered key/value table
`default_nettype none
package okvt_pkg;

  // default table geometry
  localparam int ENTRIES_DEF   = 16;
  localparam int KEY_BITS_DEF  = 32;
  localparam int DATA_BITS_DEF = 32;

  // fixed field widths on the ports
  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // request word
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } req_word_t;

  // response word
  typedef struct packed {
    logic                status;
    logic                found;
    logic [DATA_W-1:0]   data_out;
    logic [COUNT_W-1:0]  entries_used;
  } rsp_word_t;

endpackage
`default_nettype wire

>>> hw/rtl/okvt_mem.sv
// entry store: one write port and one registered read port
`default_nettype none
module okvt_mem #(
  parameter int DEPTH = okvt_pkg::ENTRIES_DEF,
  parameter int WIDTH = okvt_pkg::KEY_BITS_DEF + okvt_pkg::DATA_BITS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);
  import okvt_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ordered_key_value_table_core.sv
// Ordered key/value table: insertion-ordered association list held in one
// synchronous memory, scanned one entry per cycle.
//
// Usage: a request word (operation, key, data) is taken on req when
// req_valid and req_ready are high; exactly one response word is offered on
// rsp with rsp_valid until rsp_ready takes it. Insert appends at the tail or
// reports full, lookup returns the data of the oldest entry with an equal
// key, remove deletes all equal keys and compacts the rest in order.
// Insert and the unused code go from the execute state straight to the done
// state. Lookup and remove scan the N entries held (lookup stops early at its
// first hit): the scan issues one memory read per cycle and the compare runs
// in the cycle after each read, on the registered read data; remove writes
// survivors back behind the read pointer in the same pass. One request is in
// work at a time; a new request is taken as soon as the previous response is
// loaded into the output register, even while that response is still held.
// A stalled receiver holds the output register and the finished result waits
// in the done state. Reset empties the table (entry count zero) with no
// clearing pass; entries beyond the count are never read.
`default_nettype none
module ordered_key_value_table_core #(
  parameter int ENTRIES   = okvt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS  = okvt_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = okvt_pkg::DATA_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire okvt_pkg::req_word_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output okvt_pkg::rsp_word_t      rsp
);
  import okvt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int ENT_W = KEY_BITS + DATA_BITS;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [CNT_W-1:0]     rd_idx, rd_idx_next;
  logic [CNT_W-1:0]     wr_idx, wr_idx_next;
  logic                 chk_valid, chk_valid_next;
  logic                 res_status, res_status_next;
  logic                 res_found, res_found_next;
  logic [DATA_W-1:0]    res_dout, res_dout_next;
  logic [OP_W-1:0]      op;
  logic [KEY_W-1:0]     op_key;
  logic [DATA_W-1:0]    op_data;
  logic                 rsp_load;

  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;
  logic [ENT_W-1:0]     mem_wdata, mem_rdata;

  logic [63:0]          key64, data64, rdata64;
  logic [KEY_BITS-1:0]  key_s, rd_key;
  logic [DATA_BITS-1:0] data_s, rd_dat;
  logic                 scan_more, hit;
  logic [31:0]          count32;

  // request register
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      op      <= req.operation;
      op_key  <= req.key;
      op_data <= req.data;
    end
  end

  // stored widths of key and data
  assign key64   = {32'b0, op_key};
  assign data64  = {32'b0, op_data};
  assign key_s   = key64[KEY_BITS-1:0];
  assign data_s  = data64[DATA_BITS-1:0];
  assign rd_key  = mem_rdata[ENT_W-1:DATA_BITS];
  assign rd_dat  = mem_rdata[DATA_BITS-1:0];
  assign rdata64 = 64'(rd_dat);
  assign hit     = (rd_key == key_s);
  assign scan_more = (rd_idx < count);

  assign req_ready = (state == S_IDLE);

  // sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    rd_idx_next     = rd_idx;
    wr_idx_next     = wr_idx;
    chk_valid_next  = chk_valid;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_dout_next   = res_dout;
    rsp_load        = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = count[IDX_W-1:0];
    mem_wdata       = {key_s, data_s};
    mem_raddr       = rd_idx[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_next = 1'b0;
        res_found_next  = 1'b0;
        res_dout_next   = '0;
        rd_idx_next     = '0;
        wr_idx_next     = '0;
        chk_valid_next  = 1'b0;
        case (op)
          OP_INSERT: begin
            if (count >= CNT_W'(ENTRIES)) begin
              res_status_next = 1'b1;
            end else begin
              mem_we     = 1'b1;
              count_next = count + CNT_W'(1);
            end
            state_next = S_DONE;
          end
          OP_LOOKUP, OP_REMOVE: begin
            state_next = S_SCAN;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        // read one entry ahead of the compare
        mem_re         = scan_more;
        chk_valid_next = scan_more;
        if (scan_more) begin
          rd_idx_next = rd_idx + CNT_W'(1);
        end
        // compare the entry read last cycle
        if (chk_valid) begin
          if (op == OP_LOOKUP) begin
            if (hit) begin
              res_found_next = 1'b1;
              res_dout_next  = rdata64[DATA_W-1:0];
              chk_valid_next = 1'b0;
              state_next     = S_DONE;
            end
          end else if (hit) begin
            res_found_next = 1'b1;
          end else begin
            // keep survivor, compacted behind the read pointer
            mem_we      = 1'b1;
            mem_waddr   = wr_idx[IDX_W-1:0];
            mem_wdata   = mem_rdata;
            wr_idx_next = wr_idx + CNT_W'(1);
          end
        end
        if (!scan_more && !chk_valid) begin
          if (op == OP_REMOVE) begin
            count_next = wr_idx;
          end
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      chk_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      chk_valid <= chk_valid_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // scan pointers and result fields
  always_ff @(posedge clk) begin
    rd_idx     <= rd_idx_next;
    wr_idx     <= wr_idx_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_dout   <= res_dout_next;
  end

  // output register
  assign count32 = 32'(count);
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status       <= res_status;
      rsp.found        <= res_found;
      rsp.data_out     <= res_dout;
      rsp.entries_used <= count32[COUNT_W-1:0];
    end
  end

  okvt_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (ENT_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // entry count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count beyond table size");

  // compaction writes only slots already read
  a_write_behind: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == S_SCAN) |-> (wr_idx < rd_idx))
    else $error("compaction write ahead of read pointer");

  // an accepted word starts execution next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_EXEC))
    else $error("accepted word did not start");

  // a loaded response is offered next cycle
  a_rsp_offer: assert property (@(posedge clk) disable iff (rst)
    rsp_load |=> (rsp_valid && state == S_IDLE))
    else $error("response not offered after load");

endmodule
`default_nettype wire

>>> tb/tb_ordered_key_value_table_core.sv
// testbench for the ordered key/value table core: directed and random traffic against a table model
module tb_ordered_key_value_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import okvt_pkg::*;

  localparam int TABLE_DEPTH = ENTRIES_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int MAX_WAIT = 17;
  localparam int POOL_SIZE = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_word_t rsp;

  ordered_key_value_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // table contents as the testbench sees them
  logic [KEY_W-1:0]  table_keys [TABLE_DEPTH];
  logic [DATA_W-1:0] table_data [TABLE_DEPTH];
  int                table_count = 0;

  rsp_word_t         pending_rsp_q [$];
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];
  bit                no_idle = 1'b0;
  int                errors = 0;
  int                idle_cycles = 0;

  // apply one operation to the table and return the response word it should give
  function automatic rsp_word_t apply_table_op(req_word_t w);
    rsp_word_t r;
    int        kept;
    bit        hit;
    r = '0;
    hit = 1'b0;
    kept = 0;
    case (w.operation)
      OP_INSERT: begin
        if (table_count >= TABLE_DEPTH) begin
          r.status = 1'b1;
        end else begin
          table_keys[table_count] = w.key;
          table_data[table_count] = w.data;
          table_count++;
        end
      end
      OP_LOOKUP: begin
        // oldest matching entry wins
        for (int i = 0; i < table_count; i++) begin
          if (!hit && table_keys[i] == w.key) begin
            hit = 1'b1;
            r.found = 1'b1;
            r.data_out = table_data[i];
          end
        end
      end
      OP_REMOVE: begin
        // drop every match, keep survivors in order
        for (int i = 0; i < table_count; i++) begin
          if (table_keys[i] == w.key) begin
            r.found = 1'b1;
          end else begin
            table_keys[kept] = table_keys[i];
            table_data[kept] = table_data[i];
            kept++;
          end
        end
        table_count = kept;
      end
      default: begin
      end
    endcase
    r.entries_used = table_count[COUNT_W-1:0];
    return r;
  endfunction

  // drive one request word, wait for its handshake, record the expected response
  task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                              logic [DATA_W-1:0] d);
    req_word_t w;
    int        gap;
    w.operation = op;
    w.key = k;
    w.data = d;
    gap = no_idle ? 0 : $urandom_range(MAX_WAIT, 0);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (!(req_valid && req_ready));
    pending_rsp_q.push_back(apply_table_op(w));
  endtask

  // response side: random stalls before each word
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(MAX_WAIT, 0);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
    end
  end

  task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // compare each response word with the oldest expectation
  always @(posedge clk) begin
    rsp_word_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp_q.size() == 0) begin
        $error("response word with no request pending: %0h", rsp);
        errors++;
      end else begin
        want = pending_rsp_q.pop_front();
        check_field("status", DATA_W'(want.status), DATA_W'(rsp.status));
        check_field("found", DATA_W'(want.found), DATA_W'(rsp.found));
        check_field("data_out", want.data_out, rsp.data_out);
        check_field("entries_used", DATA_W'(want.entries_used),
                    DATA_W'(rsp.entries_used));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // lookup, remove and unused code on an empty table
  task automatic test_empty_table();
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_REMOVE, '1, '0);
    send_request(OP_UNUSED, '1, '1);
  endtask

  // extreme keys and data, duplicate keys, oldest match, remove of all matches
  task automatic test_key_extremes();
    send_request(OP_INSERT, '0, '0);
    send_request(OP_INSERT, '1, '1);
    send_request(OP_INSERT, '0, 32'h5a5a_a5a5);
    send_request(OP_LOOKUP, '0, '1);
    send_request(OP_LOOKUP, '1, '0);
    send_request(OP_REMOVE, '0, '1);
    send_request(OP_LOOKUP, '0, '0);
  endtask

  // fill to capacity, insert refused when full, remove compacts the middle
  task automatic test_full_table();
    while (table_count < TABLE_DEPTH) begin
      send_request(OP_INSERT, KEY_W'($urandom_range(3, 0)), $urandom);
    end
    send_request(OP_INSERT, 32'h1234_5678, '1);
    send_request(OP_REMOVE, KEY_W'(2), '0);
  endtask

  // random traffic over a small key pool so lookups and removes hit often
  task automatic test_random_traffic(int n, int insert_pct, int lookup_pct, bit quiet);
    int               counted;
    int               roll;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] k;
    no_idle = quiet;
    foreach (key_pool[i]) begin
      roll = $urandom_range(5, 0);
      key_pool[i] = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
    end
    counted = 0;
    while (counted < n) begin
      if ($urandom_range(99, 0) < 3) begin
        op = OP_UNUSED;
      end else begin
        roll = $urandom_range(99, 0);
        op = (roll < insert_pct) ? OP_INSERT :
             (roll < insert_pct + lookup_pct) ? OP_LOOKUP : OP_REMOVE;
      end
      k = ($urandom_range(9, 0) == 0) ? $urandom : key_pool[$urandom_range(POOL_SIZE - 1, 0)];
      send_request(op, k, $urandom);
      if (op != OP_UNUSED) counted++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_key_extremes();
    test_full_table();
    test_random_traffic(500, 60, 25, 1'b0);
    test_random_traffic(700, 40, 35, 1'b0);
    test_random_traffic(300, 20, 30, 1'b0);
    test_random_traffic(400, 40, 35, 1'b1);
    req_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/okvt_pkg.sv
hw/rtl/okvt_mem.sv
hw/rtl/ordered_key_value_table_core.sv
tb/tb_ordered_key_value_table_core.sv
